>>> rtl/fahq_pkg.sv
// Shared types, constants and a key compare helper for the four-ary min-heap queue.
package fahq_pkg;

    localparam int CAPACITY   = 256;
    localparam int DEGREE     = 4;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KEY_W      = 64;
    localparam int PAY_W      = 32;
    localparam int ENTRY_W    = KEY_W + PAY_W;
    localparam int CHILD_W    = $clog2(DEGREE + 1);
    localparam int OUT_CNT_W  = 9;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // Signed compare a < b.
    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

>>> rtl/fahq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module fahq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/four_ary_min_heap_queue.sv
// A peek reads the root; a push writes the new entry, then climbs level by level, with no climb
// into an empty heap; a pop reads the root and last entry, then descends level by level, with no
// descent when it empties the heap. Items are taken one at a time, and a pop is paced by reading
// the children one per cycle over the single read port of the entry memory.
// A waiting result holds off the next item until it has been accepted.
// Reset clears the count and the sequencer; entry memory is not cleared.
module four_ary_min_heap_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [103:0] s_tdata,  // mode[1:0], key[65:2], payload[97:66], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata   // out_key[63:0], out_payload[95:64], status[97:96],
                                   // count[106:98], zero fill
);
    import fahq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_UPRD  = 10'b0000000010,
        S_UPCMP = 10'b0000000100,
        S_ROOT  = 10'b0000001000,
        S_ROOTW = 10'b0000010000,
        S_DNRD  = 10'b0000100000,
        S_DNCMP = 10'b0001000000,
        S_DNSWP = 10'b0010000000,
        S_LAST  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;       // index of the moving entry
    logic [IDX_W-1:0] best_reg, best_next;
    logic [CHILD_W-1:0] ch_reg, ch_next;
    entry_t cur_reg, cur_next;                  // moving entry
    entry_t bestv_reg, bestv_next;
    logic [1:0] mode_reg, mode_next;
    entry_t res_reg, res_next;
    status_t st_reg, st_next;
    logic    mval_reg, mval_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata, rdata;

    fahq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [IDX_W-1:0] parent;
    logic [IDX_W+CHILD_W:0] child_idx;
    assign parent    = IDX_W'((pos_reg - 1'b1) / DEGREE);
    assign child_idx = (IDX_W+CHILD_W+1)'((IDX_W+CHILD_W+1)'(pos_reg) * DEGREE + ch_reg);

    assign s_tready = (state_reg == S_IDLE) && (!mval_reg || m_tready);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {5'd0, OUT_CNT_W'(count_reg), st_reg, res_reg.payload, res_reg.key};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        ch_next    = ch_reg;
        cur_next   = cur_reg;
        bestv_next = bestv_reg;
        mode_next  = mode_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        mval_next  = mval_reg && !m_tready;
        we    = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        raddr = parent;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    mode_next = s_tdata[1:0];
                    cur_next  = {s_tdata[65:2], s_tdata[97:66]};
                    if (s_tdata[1:0] == MODE_PUSH) begin
                        res_next = {s_tdata[65:2], s_tdata[97:66]};
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            st_next    = ST_FULL;
                            state_next = S_OUT;
                        end else begin
                            st_next    = ST_OK;
                            we         = 1'b1;
                            waddr      = IDX_W'(count_reg);
                            wdata      = {s_tdata[65:2], s_tdata[97:66]};
                            pos_next   = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                            state_next = (count_reg == '0) ? S_OUT : S_UPRD;
                        end
                    end else if (count_reg == '0) begin
                        res_next   = {KEY_MIN, {PAY_W{1'b0}}};
                        st_next    = ST_EMPTY;
                        state_next = S_OUT;
                    end else begin
                        st_next    = ST_OK;
                        raddr      = '0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_UPRD: begin
                raddr      = parent;
                state_next = S_UPCMP;
            end
            S_UPCMP: begin
                // Parent greater: move it down, carry on from its place.
                if (key_less(cur_reg.key, rdata.key)) begin
                    we       = 1'b1;
                    waddr    = pos_reg;
                    wdata    = rdata;
                    pos_next = parent;
                    state_next = (parent == '0) ? S_LAST : S_UPRD;
                end else begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = cur_reg;
                state_next = S_OUT;
            end
            S_ROOT: begin
                res_next = rdata;
                if (mode_reg == MODE_POP) begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = S_OUT;
                    end else begin
                        raddr      = IDX_W'(count_reg - 1'b1);
                        state_next = S_ROOTW;
                    end
                end else begin
                    state_next = S_OUT;
                end
            end
            S_ROOTW: begin
                cur_next   = rdata;
                pos_next   = '0;
                ch_next    = CHILD_W'(1);
                state_next = S_DNRD;
            end
            S_DNRD: begin
                best_next  = pos_reg;
                bestv_next = cur_reg;
                if (child_idx >= (IDX_W+CHILD_W+1)'(count_reg)) begin
                    state_next = S_LAST;
                end else begin
                    raddr      = IDX_W'(child_idx);
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP: begin
                // rdata is child ch_reg; issue the next child read meanwhile.
                if (key_less(rdata.key, bestv_reg.key)) begin
                    bestv_next = rdata;
                    best_next  = IDX_W'(child_idx);
                end
                if (ch_reg != CHILD_W'(DEGREE) &&
                    (child_idx + 1'b1) < (IDX_W+CHILD_W+1)'(count_reg)) begin
                    ch_next    = ch_reg + 1'b1;
                    raddr      = IDX_W'(child_idx + 1'b1);
                end else begin
                    state_next = S_DNSWP;
                end
            end
            S_DNSWP: begin
                if (best_reg == pos_reg) begin
                    state_next = S_LAST;
                end else begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = bestv_reg;
                    pos_next   = best_reg;
                    ch_next    = CHILD_W'(1);
                    state_next = S_DNRD;
                end
            end
            S_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mval_reg  <= mval_next;
        end
        pos_reg   <= pos_next;
        best_reg  <= best_next;
        ch_reg    <= ch_next;
        cur_reg   <= cur_next;
        bestv_reg <= bestv_next;
        mode_reg  <= mode_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT && mode_reg == MODE_POP) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop count wrong");
`endif
endmodule
